[rtl/llm_pkg.sv]
package llm_pkg;

   // Default sample width of the sensor converter.
   localparam int SAMPLE_BITS_DEFAULT = 12;

   // Full brightness code and register reset values.
   localparam int FULL_SCALE     = 255;
   localparam int CAL_MIN_RESET  = 0;
   localparam int CAL_MAX_RESET  = 4095;
   localparam int DEADBAND_RESET = 10;

   // Control register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_MIN  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_MAX  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESPOND
   } llm_state_type;

   // Handshake between sequencer and divider.
   typedef struct packed {
      logic start;
   } llm_div_ctrl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } llm_div_stat_type;

endpackage

[rtl/llm_csr.sv]
module llm_csr #(
   parameter int SAMPLE_BITS = llm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [llm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]            csr_data,
   output logic [SAMPLE_BITS-1:0]            cal_min,
   output logic [SAMPLE_BITS-1:0]            cal_max,
   output logic [7:0]                        deadband
);

   logic [SAMPLE_BITS-1:0] cal_min_ff;
   logic [SAMPLE_BITS-1:0] cal_max_ff;
   logic [7:0]             deadband_ff;
   logic                   wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // Writes to an index beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_min_ff  <= SAMPLE_BITS'(llm_pkg::CAL_MIN_RESET);
         cal_max_ff  <= SAMPLE_BITS'(llm_pkg::CAL_MAX_RESET);
         deadband_ff <= 8'(llm_pkg::DEADBAND_RESET);
      end else if (wr_en) begin
         case (csr_index)
            llm_pkg::CSR_CAL_MIN:  cal_min_ff  <= csr_data;
            llm_pkg::CSR_CAL_MAX:  cal_max_ff  <= csr_data;
            llm_pkg::CSR_DEADBAND: deadband_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cal_min  = cal_min_ff;
   assign cal_max  = cal_max_ff;
   assign deadband = deadband_ff;

endmodule

[rtl/llm_div.sv]
module llm_div #(
   parameter int SAMPLE_BITS = llm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  llm_pkg::llm_div_ctrl_type     ctrl,
   input  logic [SAMPLE_BITS+7:0]        dividend,
   input  logic [SAMPLE_BITS-1:0]        divisor,
   output llm_pkg::llm_div_stat_type     stat,
   output logic [SAMPLE_BITS+7:0]        quotient
);

   localparam int NW = SAMPLE_BITS + 8;
   localparam int CW = $clog2(NW + 1);

   logic [SAMPLE_BITS-1:0] rem_ff,  rem_in;
   logic [NW-1:0]          quo_ff,  quo_in;
   logic [SAMPLE_BITS-1:0] dvs_ff,  dvs_in;
   logic [CW-1:0]          cnt_ff,  cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   diff;
   logic                   fits;

   // One restoring shift-subtract step per cycle, MSB first.
   assign trial = {rem_ff, quo_ff[NW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done = done_ff;
   assign stat.busy = busy_ff;
   assign quotient  = quo_ff;

endmodule

[rtl/light_level_map_with_hysteresis_core.sv]
// Light level mapper: each req_ transfer carries one raw sensor sample, which is mapped
// linearly from [cal_min, cal_max] onto 0..255 (signed quotient truncated toward zero,
// then clamped), and the held level follows the mapped value only when the two differ by
// at least deadband. Each sample yields one rsp_ transfer with the held level and a
// range_error flag that is set, with the level left unchanged, when cal_max equals
// cal_min. The result comes from the restoring divider, which retires one quotient bit
// per cycle over SAMPLE_BITS+8 bits; the quotient is then clamped and the level
// registered. A range error skips the divider and presents its result on the cycle
// after acceptance. The block takes no new sample until the result is transferred.
// Control registers are written on the csr_ channel; the user must write them only
// while the block is idle, since the block itself does not enforce it.
module light_level_map_with_hysteresis_core #(
   parameter int SAMPLE_BITS = llm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample input
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,   // sensor_sample, zero pad
   // result output
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // level
   output logic                               rsp_tuser,   // range_error
   // control register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [llm_pkg::CSR_INDEX_BITS-1:0] csr_index,   // 0 cal_min, 1 cal_max, 2 deadband
   input  logic [SAMPLE_BITS-1:0]             csr_data
);

   localparam int NW = SAMPLE_BITS + 8;

   llm_pkg::llm_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] cal_min;
   logic [SAMPLE_BITS-1:0] cal_max;
   logic [7:0]             deadband;

   logic                   req_xfer;
   logic                   rsp_xfer;

   // operand preparation at acceptance
   logic [SAMPLE_BITS-1:0] sample;
   logic [SAMPLE_BITS:0]   num_s;      // sample - cal_min, signed
   logic [SAMPLE_BITS:0]   den_s;      // cal_max - cal_min, signed
   logic [SAMPLE_BITS-1:0] num_mag;
   logic [SAMPLE_BITS-1:0] den_mag;
   logic [NW-1:0]          num_scaled; // |num| * 255
   logic                   den_zero;
   logic                   quo_neg;

   llm_pkg::llm_div_ctrl_type div_ctrl;
   llm_pkg::llm_div_stat_type div_stat;
   logic [NW-1:0]             quotient;

   // hysteresis
   logic                   neg_ff;
   logic [7:0]             held_ff;
   logic [7:0]             mapped;
   logic [7:0]             delta;
   logic [7:0]             rsp_level_ff;
   logic                   rsp_err_ff;

   llm_csr #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cal_min   (cal_min),
      .cal_max   (cal_max),
      .deadband  (deadband)
   );

   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_tvalid & rsp_tready;

   // Work on magnitudes: a negative quotient always clamps to zero, so only the sign
   // and the unsigned quotient matter.
   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign num_s      = {1'b0, sample} - {1'b0, cal_min};
   assign den_s      = {1'b0, cal_max} - {1'b0, cal_min};
   assign num_mag    = num_s[SAMPLE_BITS] ? SAMPLE_BITS'(-num_s) : num_s[SAMPLE_BITS-1:0];
   assign den_mag    = den_s[SAMPLE_BITS] ? SAMPLE_BITS'(-den_s) : den_s[SAMPLE_BITS-1:0];
   assign num_scaled = {num_mag, 8'h00} - NW'(num_mag);
   assign den_zero   = (den_s == '0);
   assign quo_neg    = num_s[SAMPLE_BITS] ^ den_s[SAMPLE_BITS];

   llm_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (num_scaled),
      .divisor  (den_mag),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // Clamp the quotient, then compare against the held level.
   always_comb begin
      if (neg_ff) begin
         mapped = 8'h00;
      end else if (|quotient[NW-1:8]) begin
         mapped = 8'(llm_pkg::FULL_SCALE);
      end else begin
         mapped = quotient[7:0];
      end
      delta = (mapped >= held_ff) ? (mapped - held_ff) : (held_ff - mapped);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         llm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = den_zero ? llm_pkg::ST_RESPOND : llm_pkg::ST_DIVIDE;
            end
         end
         llm_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = llm_pkg::ST_RESPOND;
            end
         end
         llm_pkg::ST_RESPOND: begin
            if (rsp_xfer) begin
               state_in = llm_pkg::ST_IDLE;
            end
         end
         default: state_in = llm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      div_ctrl.start = 1'b0;
      case (state_ff)
         llm_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            div_ctrl.start = req_tvalid & ~den_zero;
         end
         llm_pkg::ST_RESPOND: begin
            rsp_tvalid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llm_pkg::ST_IDLE;
         held_ff  <= 8'h00;
      end else begin
         state_ff <= state_in;
         // Advance the held level only when the change clears the deadband.
         if (state_ff == llm_pkg::ST_DIVIDE && div_stat.done && delta >= deadband) begin
            held_ff <= mapped;
         end
      end
   end

   // result payload and quotient sign; no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         neg_ff <= quo_neg;
      end
      if (req_xfer && den_zero) begin
         rsp_level_ff <= held_ff;
         rsp_err_ff   <= 1'b1;
      end else if (state_ff == llm_pkg::ST_DIVIDE && div_stat.done) begin
         rsp_level_ff <= (delta >= deadband) ? mapped : held_ff;
         rsp_err_ff   <= 1'b0;
      end
   end

   assign rsp_tdata = rsp_level_ff;
   assign rsp_tuser = rsp_err_ff;

endmodule

[test/light_level_map_with_hysteresis_core_test.sv]
`timescale 1ns / 1ps

module light_level_map_with_hysteresis_core_test;

   localparam int SAMPLE_BITS  = 12;
   localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_ITEMS = 1800;
   localparam int TAIL_ITEMS   = 120;     // last queued entries run with no idling
   localparam int SETTLE_WAIT  = 40;      // longer than one divide pass
   localparam int LIMIT_CYCLES = 600000;

   // What one entry of the stimulus queue asks the driver to do.
   typedef enum logic [1:0] {
      STIM_SAMPLE,    // offer one sensor sample on req_
      STIM_CSR,       // wait for quiet, then write one control register
      STIM_DRAIN      // hold off until every pending result has been transferred
   } stim_kind_type;

   typedef struct {
      stim_kind_type                      kind;
      logic [llm_pkg::CSR_INDEX_BITS-1:0] index;
      logic [SAMPLE_BITS-1:0]             value;
   } stim_type;

   typedef struct packed {
      logic [7:0] level;
      logic       range_error;
   } level_result_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [TDATA_W-1:0]                 req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [7:0]                         rsp_tdata;
   logic                               rsp_tuser;
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [llm_pkg::CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [SAMPLE_BITS-1:0]             csr_data   = '0;

   light_level_map_with_hysteresis_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Level predictor: its own copy of the control registers and the held
   // level, advanced in transfer order by the monitor below.
   // ------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] span_lo    = SAMPLE_BITS'(llm_pkg::CAL_MIN_RESET);
   logic [SAMPLE_BITS-1:0] span_hi    = SAMPLE_BITS'(llm_pkg::CAL_MAX_RESET);
   logic [7:0]             band_width = 8'(llm_pkg::DEADBAND_RESET);
   logic [7:0]             level_held = 8'd0;

   function automatic level_result_type map_light_level(logic [SAMPLE_BITS-1:0] sample);
      int               span;
      int               scaled;
      int               mapped;
      int               move_size;
      level_result_type res;
      span = int'(span_hi) - int'(span_lo);
      res.range_error = 1'b0;
      // A flat calibration span has no slope: keep the level and flag it.
      if (span == 0) begin
         res.level       = level_held;
         res.range_error = 1'b1;
         return res;
      end
      // Signed quotient truncates toward zero, also for an inverted span.
      scaled = (int'(sample) - int'(span_lo)) * llm_pkg::FULL_SCALE;
      mapped = scaled / span;
      if (mapped < 0) mapped = 0;
      else if (mapped > llm_pkg::FULL_SCALE) mapped = llm_pkg::FULL_SCALE;
      move_size = mapped - int'(level_held);
      if (move_size < 0) move_size = -move_size;
      // Follow the new value only when it leaves the deadband.
      if (move_size >= int'(band_width)) level_held = mapped[7:0];
      res.level = level_held;
      return res;
   endfunction

   stim_type         pending[$];          // entries not yet offered to the block
   level_result_type level_expect_q[$];   // predicted results, oldest first
   int               samples_sent   = 0;  // samples offered on req_, driver side
   int               results_seen   = 0;  // results taken on rsp_, monitor side
   int               mismatch_count = 0;
   int               send_gap       = 0;
   int               send_idle_pct  = 20;
   int               rsp_stall      = 0;
   int               rsp_stall_pct  = 20;
   logic             calm_tail      = 1'b0;
   int               cycle_count    = 0;

   // ------------------------------------------------------------------
   // Driver: pop entries from the stimulus queue and offer them. Each
   // valid gets at most one nonblocking update per edge, none while a transfer is held.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      stim_type head;
      logic     nxt_req_valid;
      logic     nxt_csr_valid;
      logic     quiet;
      nxt_req_valid = 1'b0;
      nxt_csr_valid = 1'b0;
      quiet         = (samples_sent == results_seen);
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
         send_gap   <= 0;
      end else if ((req_tvalid && !req_tready) || (csr_valid && !csr_ready)) begin
         // hold the offered transfer until it is taken
      end else begin
         calm_tail <= (pending.size() < TAIL_ITEMS);
         if (send_gap != 0) begin
            // Count the gap down mostly while the block waits for a sample,
            // so that the idle burst lands on its ready window.
            if (req_tready || $urandom_range(0, 1) == 1) send_gap <= send_gap - 1;
         end else if (pending.size() != 0) begin
            head = pending[0];
            case (head.kind)
               STIM_SAMPLE: begin
                  nxt_req_valid = 1'b1;
                  req_tdata <= TDATA_W'(head.value);
                  samples_sent++;
                  void'(pending.pop_front());
                  if (pending.size() >= TAIL_ITEMS &&
                      $urandom_range(0, 99) < send_idle_pct)
                     send_gap <= $urandom_range(1, 12);
               end
               STIM_CSR: begin
                  // Write registers only once every result has been transferred.
                  if (quiet) begin
                     nxt_csr_valid = 1'b1;
                     csr_index <= head.index;
                     csr_data  <= head.value;
                     void'(pending.pop_front());
                  end
               end
               STIM_DRAIN: begin
                  if (quiet) begin
                     void'(pending.pop_front());
                     case ($urandom_range(0, 2))
                        0:       send_idle_pct <= 0;
                        1:       send_idle_pct <= 15;
                        default: send_idle_pct <= 50;
                     endcase
                  end
               end
               default: void'(pending.pop_front());
            endcase
         end
         req_tvalid <= nxt_req_valid;
         csr_valid  <= nxt_csr_valid;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result transfer against the oldest prediction,
   // apply register writes to the predictor, predict each accepted sample,
   // and throttle rsp_tready in random bursts.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      level_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (level_expect_q.size() == 0) begin
               $error("rsp: result transfer with no pending prediction (level %0d)",
                      rsp_tdata);
               mismatch_count++;
            end else begin
               want = level_expect_q.pop_front();
               if (rsp_tdata !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.range_error) begin
                  $error("range_error: expected %0d, got %0d", want.range_error, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               llm_pkg::CSR_CAL_MIN:  span_lo    = csr_data;
               llm_pkg::CSR_CAL_MAX:  span_hi    = csr_data;
               llm_pkg::CSR_DEADBAND: band_width = csr_data[7:0];
               default: ;
            endcase
            case ($urandom_range(0, 2))
               0:       rsp_stall_pct <= 0;
               1:       rsp_stall_pct <= 10;
               default: rsp_stall_pct <= 45;
            endcase
         end
         if (req_tvalid && req_tready)
            level_expect_q.push_back(map_light_level(req_tdata[SAMPLE_BITS-1:0]));
         if (rsp_stall != 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall  <= $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   int queued_samples = 0;

   task automatic push_sample(int value);
      stim_type s;
      s.kind  = STIM_SAMPLE;
      s.index = '0;
      s.value = SAMPLE_BITS'(value);
      pending.push_back(s);
      queued_samples++;
   endtask

   task automatic push_csr(logic [llm_pkg::CSR_INDEX_BITS-1:0] index, int value);
      stim_type s;
      s.kind  = STIM_CSR;
      s.index = index;
      s.value = SAMPLE_BITS'(value);
      pending.push_back(s);
   endtask

   task automatic push_drain();
      stim_type s;
      s.kind  = STIM_DRAIN;
      s.index = '0;
      s.value = '0;
      pending.push_back(s);
   endtask

   initial begin
      int lo;
      int hi;
      int prev;
      int count;
      int pick;
      int top;
      int bottom;

      // Directed: reset calibration, full range with the default deadband.
      push_sample(0);
      push_sample(SAMPLE_MAX);
      push_sample(2048);
      push_sample(SAMPLE_MAX - 5);    // large move up from mid-scale clears the deadband
      push_sample(SAMPLE_MAX - 1);
      push_drain();                    // pause the sender until all results are in

      // Zero deadband: every step moves the level.
      push_csr(llm_pkg::CSR_DEADBAND, 0);
      push_sample(1);
      push_sample(17);
      push_sample(0);

      // Widest deadband, written with upper data bits set (masked to 8 bits).
      push_csr(llm_pkg::CSR_DEADBAND, 12'hFFF);
      push_sample(SAMPLE_MAX);
      push_sample(2048);

      // Flat calibration span in the middle and at both ends.
      push_csr(llm_pkg::CSR_CAL_MIN, 2000);
      push_csr(llm_pkg::CSR_CAL_MAX, 2000);
      push_sample(0);
      push_sample(SAMPLE_MAX);
      push_csr(llm_pkg::CSR_CAL_MIN, 0);
      push_csr(llm_pkg::CSR_CAL_MAX, 0);
      push_sample(1);
      push_csr(llm_pkg::CSR_CAL_MIN, SAMPLE_MAX);
      push_csr(llm_pkg::CSR_CAL_MAX, SAMPLE_MAX);
      push_sample(SAMPLE_MAX);

      // Inverted span: negative divisor, quotient truncated then clamped.
      push_csr(llm_pkg::CSR_CAL_MAX, 0);
      push_csr(llm_pkg::CSR_DEADBAND, 10);
      push_sample(0);
      push_sample(SAMPLE_MAX);
      push_sample(2000);

      // One-step span: clamp below cal_min and far above cal_max.
      push_csr(llm_pkg::CSR_CAL_MIN, 1000);
      push_csr(llm_pkg::CSR_CAL_MAX, 1001);
      push_sample(999);
      push_sample(1001);
      push_sample(SAMPLE_MAX);
      push_sample(1000);

      // Random phases: a fresh calibration, then a run of samples.
      lo   = 1000;
      hi   = 1001;
      prev = 1000;
      while (queued_samples < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            push_drain();
         end else begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: begin lo = 0; hi = SAMPLE_MAX; end
               1: begin lo = $urandom_range(0, SAMPLE_MAX); hi = lo; end
               2: begin lo = SAMPLE_MAX; hi = 0; end
               3: begin
                  hi = $urandom_range(0, SAMPLE_MAX - 1);
                  lo = $urandom_range(hi + 1, SAMPLE_MAX);
               end
               4: begin
                  lo = $urandom_range(0, SAMPLE_MAX - 8);
                  hi = lo + $urandom_range(1, 8);
               end
               default: begin
                  lo = $urandom_range(0, SAMPLE_MAX);
                  hi = $urandom_range(0, SAMPLE_MAX);
               end
            endcase
            push_csr(llm_pkg::CSR_CAL_MIN, lo);
            push_csr(llm_pkg::CSR_CAL_MAX, hi);
            case ($urandom_range(0, 5))
               0:       push_csr(llm_pkg::CSR_DEADBAND, 0);
               1:       push_csr(llm_pkg::CSR_DEADBAND, 255);
               2:       push_csr(llm_pkg::CSR_DEADBAND, $urandom_range(0, SAMPLE_MAX));
               default: push_csr(llm_pkg::CSR_DEADBAND, $urandom_range(0, 40));
            endcase
         end
         bottom = (lo < hi) ? lo : hi;
         top    = (lo < hi) ? hi : lo;
         count  = $urandom_range(20, 80);
         repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               prev = $urandom_range(0, SAMPLE_MAX);
            end else if (pick < 7) begin
               prev = $urandom_range(bottom, top);
            end else begin
               // Creep around the previous sample to work the deadband.
               prev = prev + int'($urandom_range(0, 80)) - 40;
               if (prev < 0) prev = 0;
               if (prev > SAMPLE_MAX) prev = SAMPLE_MAX;
            end
            push_sample(prev);
         end
      end

      // Wait for the queue to empty and every prediction to be matched.
      @(negedge reset);
      while (pending.size() != 0 || req_tvalid || csr_valid ||
             samples_sent != results_seen)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatch_count == 0 && level_expect_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[light_level_map_with_hysteresis_core.f]
rtl/llm_pkg.sv
rtl/llm_csr.sv
rtl/llm_div.sv
rtl/light_level_map_with_hysteresis_core.sv
test/light_level_map_with_hysteresis_core_test.sv
